### rtl/jdr_pkg.sv
// ----------------------------------------------------------------------------
// jdr_pkg
// shared constants for the joybus device responder: phase codes, register
// indexes, command codes and field widths
// ----------------------------------------------------------------------------
`default_nettype none

package jdr_pkg;

  // register indexes on the configuration channel
  localparam logic [2:0] REG_UNIT_TICKS   = 3'd0;
  localparam logic [2:0] REG_IDLE_TICKS   = 3'd1;
  localparam logic [2:0] REG_IDENT_REPLY  = 3'd2;
  localparam logic [2:0] REG_STATUS_REPLY = 3'd3;
  localparam logic [2:0] REG_LONG_STOP    = 3'd4;

  // register reset values
  localparam logic [7:0]  UNIT_TICKS_RST   = 8'd16;
  localparam logic [7:0]  IDLE_TICKS_RST   = 8'd16;
  localparam logic [23:0] IDENT_REPLY_RST  = 24'h050002;
  localparam logic [31:0] STATUS_REPLY_RST = 32'h55555555;

  // receive / transmit phases
  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_CMD_LOW    = 3'd1;
  localparam logic [2:0] PH_CMD_SAMPLE = 3'd2;
  localparam logic [2:0] PH_CMD_HIGH   = 3'd3;
  localparam logic [2:0] PH_TR_HIGH    = 3'd4;
  localparam logic [2:0] PH_TR_LOW     = 3'd5;
  localparam logic [2:0] PH_TR_SAMPLE  = 3'd6;
  localparam logic [2:0] PH_REPLY      = 3'd7;

  // command codes
  localparam logic [7:0] CMD_IDENT     = 8'h00;
  localparam logic [7:0] CMD_STATUS    = 8'h01;
  localparam logic [7:0] CMD_READ      = 8'h02;
  localparam logic [7:0] CMD_WRITE     = 8'h03;
  localparam logic [7:0] CMD_RESET     = 8'hFF;

  // trailing bit counts, including the host stop bit
  localparam logic [8:0] TRAIL_WRITE   = 9'd273;
  localparam logic [8:0] TRAIL_READ    = 9'd17;
  localparam logic [8:0] TRAIL_OTHER   = 9'd1;
  localparam logic [8:0] CMD_BITS      = 9'd8;

  localparam logic [5:0] IDENT_BITS    = 6'd24;
  localparam logic [5:0] STATUS_BITS   = 6'd32;

  localparam logic [7:0] IDLE_RUN_MAX  = 8'd255;

  // result item as packed into the output tdata, highest field first
  typedef struct packed {
    logic [4:0] pad;
    logic       replying;
    logic [7:0] command_code;
    logic       command_valid;
    logic       drive_low;
  } result_t;

endpackage

`default_nettype wire

### rtl/joybus_device_responder.sv
// ----------------------------------------------------------------------------
// joybus_device_responder
// device side of a one-wire controller bus, one line sample in and one
// drive value out per item
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one sample of the bus line per item (tdata bit 0). each
//   accepted sample advances the bit decoder / reply transmitter by one tick
//   and yields exactly one result item on m_axis.
//   cfg writes set the timing unit, idle length, reply bytes and stop width;
//   write them only while no item is in flight. cfg_ready is always high.
// latency and throughput:
//   the result of a sample sits in the output register on the cycle after
//   the sample is accepted. unless stalled, one item per cycle is sustained:
//   the single output register is refilled in the same cycle it is drained,
//   and the state update is one short pass of compare and increment logic.
// stalls:
//   when m_axis_tready is low with a result waiting, s_axis_tready drops and
//   the decoder state holds, so no tick is lost or duplicated.
// reset:
//   rst (synchronous, active high) returns the decoder to idle wait, clears
//   the latched command code, empties the output register and loads the
//   register defaults (unit 16, idle 16, ident 050002, status 55555555).
// ----------------------------------------------------------------------------
`default_nettype none

module joybus_device_responder (
  input  wire logic        clk,
  input  wire logic        rst,
  // sample stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] line_high, [7:1] zero
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [0] drive_low, [1] command_valid,
                                           // [9:2] command_code, [10] replying,
                                           // [15:11] zero
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // configuration registers
  logic [7:0]  unit_ticks;
  logic [7:0]  idle_ticks;
  logic [23:0] ident_reply;
  logic [31:0] status_reply;
  logic        long_stop;

  // decoder state
  logic [2:0]  phase,           phase_next;
  logic [9:0]  tick_count,      tick_count_next;
  logic [7:0]  idle_run,        idle_run_next;
  logic [7:0]  command_shift,   command_shift_next;
  logic [8:0]  bits_left,       bits_left_next;
  logic [31:0] reply_shift,     reply_shift_next;
  logic [5:0]  reply_bits_left, reply_bits_left_next;
  logic        current_bit,     current_bit_next;
  logic [7:0]  code_latch,      code_latch_next;

  jdr_pkg::result_t result_next;
  logic [15:0]      result;

  logic accept;
  logic line;

  // timing derived from the unit
  logic [7:0] unit;
  logic [8:0] two_unit;
  logic [9:0] three_unit;
  logic [9:0] four_unit;
  logic [7:0] idle_need;
  logic [7:0] idle_run_inc;
  logic [9:0] tick_inc;
  logic [9:0] low_time;
  logic [9:0] stop_low;
  logic [7:0] shifted_cmd;
  logic [8:0] bits_dec;
  logic [31:0] reply_shifted;

  assign cfg_ready     = 1'b1;
  // output register drains and refills in the same cycle
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign line          = s_axis_tdata[0];
  assign m_axis_tdata  = result;

  // zero unit or zero idle length act as one
  assign unit         = (unit_ticks == 8'd0) ? 8'd1 : unit_ticks;
  assign idle_need    = (idle_ticks == 8'd0) ? 8'd1 : idle_ticks;
  assign two_unit     = {unit, 1'b0};
  assign three_unit   = {1'b0, two_unit} + {2'b00, unit};
  assign four_unit    = {unit, 2'b00};
  assign idle_run_inc = (idle_run == jdr_pkg::IDLE_RUN_MAX) ? idle_run : idle_run + 8'd1;
  assign tick_inc     = tick_count + 10'd1;
  assign low_time     = current_bit ? {2'b00, unit} : three_unit;
  assign stop_low     = long_stop ? {1'b0, two_unit} : {2'b00, unit};
  assign shifted_cmd  = {command_shift[6:0], line};
  assign bits_dec     = bits_left - 9'd1;
  assign reply_shifted = {reply_shift[30:0], 1'b0};

  always_comb begin
    phase_next           = phase;
    tick_count_next      = tick_count;
    idle_run_next        = idle_run;
    command_shift_next   = command_shift;
    bits_left_next       = bits_left;
    reply_shift_next     = reply_shift;
    reply_bits_left_next = reply_bits_left;
    current_bit_next     = current_bit;
    code_latch_next      = code_latch;
    result_next          = '0;

    unique case (phase)
      jdr_pkg::PH_IDLE: begin
        if (line) begin
          idle_run_next = idle_run_inc;
          if (idle_run_inc >= idle_need) begin
            phase_next         = jdr_pkg::PH_CMD_LOW;
            command_shift_next = 8'd0;
            bits_left_next     = jdr_pkg::CMD_BITS;
          end
        end else begin
          idle_run_next = 8'd0;
        end
      end
      jdr_pkg::PH_CMD_LOW, jdr_pkg::PH_TR_LOW: begin
        // falling edge starts the sample timer
        if (!line) begin
          tick_count_next = 10'd0;
          phase_next = (phase == jdr_pkg::PH_CMD_LOW) ? jdr_pkg::PH_CMD_SAMPLE
                                                      : jdr_pkg::PH_TR_SAMPLE;
        end
      end
      jdr_pkg::PH_CMD_SAMPLE: begin
        tick_count_next = tick_inc;
        if (tick_inc >= {1'b0, two_unit}) begin
          command_shift_next = shifted_cmd;
          bits_left_next     = bits_dec;
          if (bits_dec == 9'd0) begin
            code_latch_next           = shifted_cmd;
            result_next.command_valid = 1'b1;
            if (shifted_cmd == jdr_pkg::CMD_WRITE) begin
              bits_left_next = jdr_pkg::TRAIL_WRITE;
            end else if (shifted_cmd == jdr_pkg::CMD_READ) begin
              bits_left_next = jdr_pkg::TRAIL_READ;
            end else begin
              bits_left_next = jdr_pkg::TRAIL_OTHER;
            end
            phase_next = jdr_pkg::PH_TR_HIGH;
          end else begin
            phase_next = jdr_pkg::PH_CMD_HIGH;
          end
        end
      end
      jdr_pkg::PH_CMD_HIGH, jdr_pkg::PH_TR_HIGH: begin
        if (line) begin
          phase_next = (phase == jdr_pkg::PH_CMD_HIGH) ? jdr_pkg::PH_CMD_LOW
                                                       : jdr_pkg::PH_TR_LOW;
        end
      end
      jdr_pkg::PH_TR_SAMPLE: begin
        tick_count_next = tick_inc;
        if (tick_inc >= {1'b0, two_unit}) begin
          bits_left_next = bits_dec;
          if (bits_dec == 9'd0) begin
            // last trailing bit: start the reply, or go back to idle wait
            if (code_latch == jdr_pkg::CMD_IDENT || code_latch == jdr_pkg::CMD_RESET) begin
              reply_shift_next     = {ident_reply, 8'h00};
              reply_bits_left_next = jdr_pkg::IDENT_BITS;
              current_bit_next     = ident_reply[23];
              tick_count_next      = 10'd0;
              phase_next           = jdr_pkg::PH_REPLY;
            end else if (code_latch == jdr_pkg::CMD_STATUS) begin
              reply_shift_next     = status_reply;
              reply_bits_left_next = jdr_pkg::STATUS_BITS;
              current_bit_next     = status_reply[31];
              tick_count_next      = 10'd0;
              phase_next           = jdr_pkg::PH_REPLY;
            end else begin
              phase_next      = jdr_pkg::PH_IDLE;
              idle_run_next   = 8'd0;
              tick_count_next = 10'd0;
            end
          end else begin
            phase_next = jdr_pkg::PH_TR_HIGH;
          end
        end
      end
      jdr_pkg::PH_REPLY: begin
        result_next.replying = 1'b1;
        tick_count_next      = tick_inc;
        if (reply_bits_left != 6'd0) begin
          // data bit: low for one or three units out of four
          result_next.drive_low = (tick_count < low_time);
          if (tick_inc >= four_unit) begin
            tick_count_next      = 10'd0;
            reply_bits_left_next = reply_bits_left - 6'd1;
            reply_shift_next     = reply_shifted;
            current_bit_next     = reply_shifted[31];
          end
        end else begin
          // stop bit
          result_next.drive_low = 1'b1;
          if (tick_inc >= stop_low) begin
            phase_next      = jdr_pkg::PH_IDLE;
            idle_run_next   = 8'd0;
            tick_count_next = 10'd0;
          end
        end
      end
      default: begin
        phase_next = jdr_pkg::PH_IDLE;
      end
    endcase

    result_next.command_code = code_latch_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks   <= jdr_pkg::UNIT_TICKS_RST;
      idle_ticks   <= jdr_pkg::IDLE_TICKS_RST;
      ident_reply  <= jdr_pkg::IDENT_REPLY_RST;
      status_reply <= jdr_pkg::STATUS_REPLY_RST;
      long_stop    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        jdr_pkg::REG_UNIT_TICKS:   unit_ticks   <= cfg_data[7:0];
        jdr_pkg::REG_IDLE_TICKS:   idle_ticks   <= cfg_data[7:0];
        jdr_pkg::REG_IDENT_REPLY:  ident_reply  <= cfg_data[23:0];
        jdr_pkg::REG_STATUS_REPLY: status_reply <= cfg_data;
        jdr_pkg::REG_LONG_STOP:    long_stop    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // decoder state advances once per accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= jdr_pkg::PH_IDLE;
      tick_count      <= 10'd0;
      idle_run        <= 8'd0;
      command_shift   <= 8'd0;
      bits_left       <= 9'd0;
      reply_shift     <= 32'd0;
      reply_bits_left <= 6'd0;
      current_bit     <= 1'b0;
      code_latch      <= 8'd0;
    end else if (accept) begin
      phase           <= phase_next;
      tick_count      <= tick_count_next;
      idle_run        <= idle_run_next;
      command_shift   <= command_shift_next;
      bits_left       <= bits_left_next;
      reply_shift     <= reply_shift_next;
      reply_bits_left <= reply_bits_left_next;
      current_bit     <= current_bit_next;
      code_latch      <= code_latch_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

### sim/jdr_reply_checker.sv
// ----------------------------------------------------------------------------
// jdr_reply_checker
// watches the sample, result and configuration channels of the joybus
// device responder, predicts every result item tick by tick and compares
// ----------------------------------------------------------------------------
module jdr_reply_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          samples_seen,
  output int          commands_seen,
  output int          reply_ticks
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copy
  logic [7:0]  unit_cfg;
  logic [7:0]  idle_cfg;
  logic [23:0] ident_cfg;
  logic [31:0] status_cfg;
  logic        wide_cfg;

  // decoder / transmitter copy
  logic [2:0]  ph;
  logic [9:0]  tick_cnt;
  logic [7:0]  idle_run;
  logic [7:0]  cmd_sr;
  logic [8:0]  bits_left;
  logic [31:0] rsp_sr;
  logic [5:0]  rsp_bits;
  logic        cur_bit;
  logic [7:0]  code_hold;

  jdr_pkg::result_t due_responses[$];

  task automatic flag_error(input string msg);
    if (errors < 40) $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // one tick of the responder for one line sample
  function automatic jdr_pkg::result_t line_tick_response(input logic line);
    jdr_pkg::result_t r;
    int u;
    int need;
    int low_len;
    r = '0;
    u = (unit_cfg == 8'd0) ? 1 : int'(unit_cfg);
    case (ph)
      jdr_pkg::PH_IDLE: begin
        if (line) begin
          need = (idle_cfg == 8'd0) ? 1 : int'(idle_cfg);
          if (idle_run < jdr_pkg::IDLE_RUN_MAX) idle_run = idle_run + 8'd1;
          if (int'(idle_run) >= need) begin
            ph = jdr_pkg::PH_CMD_LOW;
            cmd_sr = 8'd0;
            bits_left = jdr_pkg::CMD_BITS;
          end
        end else begin
          idle_run = 8'd0;
        end
      end
      jdr_pkg::PH_CMD_LOW, jdr_pkg::PH_TR_LOW: begin
        if (!line) begin
          tick_cnt = 10'd0;
          ph = (ph == jdr_pkg::PH_CMD_LOW) ? jdr_pkg::PH_CMD_SAMPLE : jdr_pkg::PH_TR_SAMPLE;
        end
      end
      jdr_pkg::PH_CMD_SAMPLE: begin
        tick_cnt = tick_cnt + 10'd1;
        if (int'(tick_cnt) >= 2 * u) begin
          cmd_sr = {cmd_sr[6:0], line};
          bits_left = bits_left - 9'd1;
          if (bits_left == 9'd0) begin
            code_hold = cmd_sr;
            r.command_valid = 1'b1;
            if (cmd_sr == jdr_pkg::CMD_WRITE) bits_left = jdr_pkg::TRAIL_WRITE;
            else if (cmd_sr == jdr_pkg::CMD_READ) bits_left = jdr_pkg::TRAIL_READ;
            else bits_left = jdr_pkg::TRAIL_OTHER;
            ph = jdr_pkg::PH_TR_HIGH;
          end else begin
            ph = jdr_pkg::PH_CMD_HIGH;
          end
        end
      end
      jdr_pkg::PH_CMD_HIGH, jdr_pkg::PH_TR_HIGH: begin
        if (line) ph = (ph == jdr_pkg::PH_CMD_HIGH) ? jdr_pkg::PH_CMD_LOW : jdr_pkg::PH_TR_LOW;
      end
      jdr_pkg::PH_TR_SAMPLE: begin
        tick_cnt = tick_cnt + 10'd1;
        if (int'(tick_cnt) >= 2 * u) begin
          bits_left = bits_left - 9'd1;
          if (bits_left != 9'd0) begin
            ph = jdr_pkg::PH_TR_HIGH;
          end else if (code_hold == jdr_pkg::CMD_IDENT || code_hold == jdr_pkg::CMD_RESET) begin
            rsp_sr = {ident_cfg, 8'h00};
            rsp_bits = jdr_pkg::IDENT_BITS;
            cur_bit = rsp_sr[31];
            tick_cnt = 10'd0;
            ph = jdr_pkg::PH_REPLY;
          end else if (code_hold == jdr_pkg::CMD_STATUS) begin
            rsp_sr = status_cfg;
            rsp_bits = jdr_pkg::STATUS_BITS;
            cur_bit = rsp_sr[31];
            tick_cnt = 10'd0;
            ph = jdr_pkg::PH_REPLY;
          end else begin
            // no answer for this command, straight back to idle wait
            ph = jdr_pkg::PH_IDLE;
            idle_run = 8'd0;
            tick_cnt = 10'd0;
          end
        end
      end
      default: begin
        r.replying = 1'b1;
        if (rsp_bits != 6'd0) begin
          low_len = cur_bit ? u : 3 * u;
          r.drive_low = (int'(tick_cnt) < low_len);
          tick_cnt = tick_cnt + 10'd1;
          if (int'(tick_cnt) >= 4 * u) begin
            tick_cnt = 10'd0;
            rsp_bits = rsp_bits - 6'd1;
            rsp_sr = rsp_sr << 1;
            cur_bit = rsp_sr[31];
          end
        end else begin
          // stop bit
          r.drive_low = 1'b1;
          tick_cnt = tick_cnt + 10'd1;
          if (int'(tick_cnt) >= (wide_cfg ? 2 * u : u)) begin
            ph = jdr_pkg::PH_IDLE;
            idle_run = 8'd0;
            tick_cnt = 10'd0;
          end
        end
      end
    endcase
    r.command_code = code_hold;
    return r;
  endfunction

  always @(posedge clk) begin
    jdr_pkg::result_t got;
    jdr_pkg::result_t want;
    if (rst) begin
      unit_cfg = jdr_pkg::UNIT_TICKS_RST;
      idle_cfg = jdr_pkg::IDLE_TICKS_RST;
      ident_cfg = jdr_pkg::IDENT_REPLY_RST;
      status_cfg = jdr_pkg::STATUS_REPLY_RST;
      wide_cfg = 1'b0;
      ph = jdr_pkg::PH_IDLE;
      tick_cnt = '0;
      idle_run = '0;
      cmd_sr = '0;
      bits_left = '0;
      rsp_sr = '0;
      rsp_bits = '0;
      cur_bit = 1'b0;
      code_hold = '0;
      due_responses.delete();
      errors = 0;
      pending = 0;
      samples_seen = 0;
      commands_seen = 0;
      reply_ticks = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = jdr_pkg::result_t'(m_tdata);
        if (due_responses.size() == 0) begin
          flag_error($sformatf("result %h with nothing due", m_tdata));
        end else begin
          want = due_responses.pop_front();
          if (got.drive_low !== want.drive_low || got.command_valid !== want.command_valid ||
              got.command_code !== want.command_code || got.replying !== want.replying)
            flag_error($sformatf({"drive %b/%b valid %b/%b code %h/%h replying %b/%b",
                                  " (got/expected)"},
                                 got.drive_low, want.drive_low,
                                 got.command_valid, want.command_valid,
                                 got.command_code, want.command_code,
                                 got.replying, want.replying));
          if (want.command_valid) commands_seen++;
          if (want.replying) reply_ticks++;
        end
      end
      if (s_tvalid && s_tready) begin
        due_responses.push_back(line_tick_response(s_tdata[0]));
        samples_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          jdr_pkg::REG_UNIT_TICKS:   unit_cfg = cfg_data[7:0];
          jdr_pkg::REG_IDLE_TICKS:   idle_cfg = cfg_data[7:0];
          jdr_pkg::REG_IDENT_REPLY:  ident_cfg = cfg_data[23:0];
          jdr_pkg::REG_STATUS_REPLY: status_cfg = cfg_data;
          jdr_pkg::REG_LONG_STOP:    wide_cfg = cfg_data[0];
          default: ;
        endcase
      end
      pending = due_responses.size();
    end
  end

endmodule

### sim/joybus_device_responder_test.sv
// ----------------------------------------------------------------------------
// joybus_device_responder_test
// drives host frames (idle runs, command bytes, trailing bits) into the
// responder one line sample per item under several register settings and
// idle/stall mixes; a checker beside the block predicts every result item
// and counts mismatches
// ----------------------------------------------------------------------------
module joybus_device_responder_test;
  timeunit 1ns;
  timeprecision 1ps;

  // a command the block does not answer
  localparam logic [7:0] CMD_UNKNOWN = 8'hA5;
  // length of the long output hold, in cycles
  localparam int OUT_HOLD_CYCLES = 300;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [0] line_high, [7:1] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [0] drive_low, [1] command_valid, [9:2] command_code,
                               // [10] replying, [15:11] zero
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  int errors;
  int owed;
  int samples_seen;
  int commands_seen;
  int reply_ticks;

  // stimulus view of the current settings, used only to time host frames
  int unit_now;
  int idle_now;
  bit wide_now;

  // idling mix: percent of cycles the sender idles / the receiver stalls
  int src_gap_pct;
  int sink_stall_pct;
  bit hold_req;

  joybus_device_responder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  jdr_reply_checker reply_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_axis_tvalid),
    .s_tready      (s_axis_tready),
    .s_tdata       (s_axis_tdata),
    .m_tvalid      (m_axis_tvalid),
    .m_tready      (m_axis_tready),
    .m_tdata       (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (owed),
    .samples_seen  (samples_seen),
    .commands_seen (commands_seen),
    .reply_ticks   (reply_ticks)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #10ms;
    $display("timeout with %0d results still due", owed);
    $display("joybus_device_responder_test NOT OK");
    $finish;
  end

  // result side: random stalls, plus one long hold when asked
  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = OUT_HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // offer one line sample, with a random idle gap in front; entered and left
  // at a falling edge, tvalid stays high on return
  task automatic push_sample(input logic lvl);
    while ($urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, lvl};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_level(input logic lvl, input int n);
    repeat (n) push_sample(lvl);
  endtask

  // host bit: a 1 is low one unit then high three, a 0 the other way round;
  // a little extra high time is harmless since the block waits for the edge
  task automatic host_bit(input logic b);
    send_level(1'b0, b ? unit_now : 3 * unit_now);
    send_level(1'b1, (b ? 3 * unit_now : unit_now) + $urandom_range(0, 2));
  endtask

  // idle run, command byte (possibly cut after nbits), trailing bits with
  // the host stop bit, then the line left high while the reply goes out
  task automatic host_frame(input logic [7:0] cmd, input int nbits);
    int trail;
    int reply_len;
    send_level(1'b1, idle_now + $urandom_range(0, 3));
    for (int i = 7; i > 7 - nbits; i--) host_bit(cmd[i]);
    if (nbits < 8) begin
      // cut frame: the block is left mid-command
      send_level(1'b1, 4);
    end else begin
      if (cmd == jdr_pkg::CMD_WRITE) trail = jdr_pkg::TRAIL_WRITE;
      else if (cmd == jdr_pkg::CMD_READ) trail = jdr_pkg::TRAIL_READ;
      else trail = jdr_pkg::TRAIL_OTHER;
      repeat (trail - 1) host_bit(1'($urandom_range(0, 1)));
      host_bit(1'b1);
      if (cmd == jdr_pkg::CMD_IDENT || cmd == jdr_pkg::CMD_RESET)
        reply_len = jdr_pkg::IDENT_BITS * 4 * unit_now;
      else if (cmd == jdr_pkg::CMD_STATUS)
        reply_len = jdr_pkg::STATUS_BITS * 4 * unit_now;
      else reply_len = 0;
      if (reply_len != 0) reply_len += (wide_now ? 2 : 1) * unit_now;
      send_level(1'b1, reply_len + 2);
    end
  endtask

  // stop offering and wait until every result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (owed != 0) @(negedge clk);
  endtask

  // cfg_valid is left high between writes and lowered by the caller
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] unit, input logic [7:0] idle,
                                input logic [23:0] ident, input logic [31:0] status,
                                input bit wide);
    write_reg(jdr_pkg::REG_UNIT_TICKS, {24'd0, unit});
    write_reg(jdr_pkg::REG_IDLE_TICKS, {24'd0, idle});
    write_reg(jdr_pkg::REG_IDENT_REPLY, {8'd0, ident});
    write_reg(jdr_pkg::REG_STATUS_REPLY, status);
    write_reg(jdr_pkg::REG_LONG_STOP, {31'd0, wide});
    cfg_valid <= 1'b0;
    // zero unit or idle length behaves as one
    unit_now = (unit == 8'd0) ? 1 : int'(unit);
    idle_now = (idle == 8'd0) ? 1 : int'(idle);
    wide_now = wide;
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'd0;
    cfg_valid = 1'b0;
    cfg_index = jdr_pkg::REG_UNIT_TICKS;
    cfg_data = 32'd0;
    src_gap_pct = 0;
    sink_stall_pct = 0;
    hold_req = 1'b0;
    unit_now = int'(jdr_pkg::UNIT_TICKS_RST);
    idle_now = int'(jdr_pkg::IDLE_TICKS_RST);
    wide_now = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: idle run broken by a low sample, then a full idle run
    // so the block waits for the first command edge
    send_level(1'b1, 10);
    send_level(1'b0, 1);
    send_level(1'b1, 20);
    drain();

    // fastest timing, all-ones identify, wide stop, no idling
    apply_settings(8'd1, 8'd1, 24'hFFFFFF, 32'h0, 1'b1);
    host_frame(jdr_pkg::CMD_RESET, 8);
    drain();

    // zero unit and idle length, sender idling about half the time
    apply_settings(8'd0, 8'd0, 24'h0, 32'hFFFFFFFF, 1'b0);
    src_gap_pct = 49;
    host_frame(CMD_UNKNOWN, 8);
    drain();

    // receiver stalling, and one long output hold so the block backs up
    // into its input
    apply_settings(8'd2, 8'd5, 24'($urandom), $urandom, 1'b1);
    src_gap_pct = 0;
    sink_stall_pct = 49;
    hold_req = 1'b1;
    host_frame(CMD_UNKNOWN, 8);
    drain();

    // light idling on both sides, status reply with random contents
    apply_settings(8'd1, 8'($urandom_range(1, 6)), 24'($urandom), $urandom, 1'b0);
    src_gap_pct = 9;
    sink_stall_pct = 9;
    host_frame(jdr_pkg::CMD_STATUS, 8);
    drain();

    // wait for anything stray left in the single result register
    repeat (8) @(negedge clk);
    $display("covered %0d line samples, %0d decoded commands, %0d reply ticks",
             samples_seen, commands_seen, reply_ticks);
    $display("reset, status and unanswered commands, zero and short units, both stop widths");
    if (errors == 0) begin
      $display("joybus_device_responder_test OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("joybus_device_responder_test NOT OK");
    end
    $finish;
  end

endmodule
